FILE: rtl/kbpt_pkg.sv
// Shared types and constants for the box pruning test pipeline.
`timescale 1ns / 1ps

package kbpt_pkg;

    // width of each packed coordinate port
    localparam int IN_WIDTH = 48;

    // per-stage advance enables, driven by the top level
    typedef struct packed {
        logic op;    // operand stage (difference, corner select, clamp)
        logic prod;  // product stage
        logic sum;   // lane merge (sums)
        logic flag;  // compare and output word
    } pipe_en_t;

endpackage

FILE: rtl/kbpt_lane.sv
// One dimension lane: difference, corner select, clamp and the two fixed-point products.
`timescale 1ns / 1ps

module kbpt_lane
    import kbpt_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int EXT_WIDTH     = 32,
    parameter int MUL_INT_BITS  = 13,
    parameter int MUL_FRAC_BITS = 4
)
(
    input  logic                   clk,
    input  pipe_en_t               en,
    input  logic [COORD_WIDTH-1:0] closest,
    input  logic [COORD_WIDTH-1:0] cand,
    input  logic [COORD_WIDTH-1:0] lo,
    input  logic [COORD_WIDTH-1:0] hi,
    output logic [EXT_WIDTH-1:0]   term_a,
    output logic [EXT_WIDTH-1:0]   term_b
);

    // differences of two coordinates never need more than one extra bit
    localparam int DW  = COORD_WIDTH + 1;
    localparam int MB  = MUL_INT_BITS + MUL_FRAC_BITS;
    localparam int OPW = (MB < DW) ? MB : DW;
    localparam int PRW = 2 * OPW;
    localparam int WW  = PRW + EXT_WIDTH;
    localparam logic signed [DW-1:0] OP_MAX = DW'((64'sd1 <<< (OPW - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] OP_MIN = ~OP_MAX;

    logic signed [DW-1:0]  cl_x, ca_x, lo_x, hi_x;
    logic signed [DW-1:0]  c, corner, diff;
    logic                  pos;
    logic signed [OPW-1:0] c_op_reg, c_op_next, d_op_reg, d_op_next;
    logic signed [PRW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic signed [WW-1:0]  wa, wb, sa, sb;

    function automatic logic signed [OPW-1:0] clamp_op(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > OP_MAX)
            r = OP_MAX;
        else if (v < OP_MIN)
            r = OP_MIN;
        else
            r = v;
        return r[OPW-1:0];
    endfunction

    assign cl_x = {closest[COORD_WIDTH-1], closest};
    assign ca_x = {cand[COORD_WIDTH-1], cand};
    assign lo_x = {lo[COORD_WIDTH-1], lo};
    assign hi_x = {hi[COORD_WIDTH-1], hi};

    assign c      = ca_x - cl_x;
    assign pos    = !c[DW-1] && (c != '0);
    assign corner = pos ? hi_x : lo_x;
    assign diff   = corner - cl_x;

    assign c_op_next = clamp_op(c);
    assign d_op_next = clamp_op(diff);
    assign pa_next   = PRW'(c_op_reg) * PRW'(c_op_reg);
    assign pb_next   = PRW'(d_op_reg) * PRW'(c_op_reg);

    always_ff @(posedge clk)
    begin
        if (en.op)
        begin
            c_op_reg <= c_op_next;
            d_op_reg <= d_op_next;
        end
        if (en.prod)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // drop the fraction bits, then truncate or sign-extend to the sum width
    assign wa = WW'(pa_reg);
    assign wb = WW'(pb_reg);
    assign sa = wa >>> MUL_FRAC_BITS;
    assign sb = wb >>> MUL_FRAC_BITS;

    assign term_a = sa[EXT_WIDTH-1:0];
    assign term_b = sb[EXT_WIDTH-1:0];

endmodule

FILE: rtl/kbpt_merge.sv
// Merge stage: wrapping sums over the lanes and the signed distance compare.
`timescale 1ns / 1ps

module kbpt_merge
    import kbpt_pkg::*;
#(
    parameter int DIMS      = 3,
    parameter int EXT_WIDTH = 32
)
(
    input  logic                             clk,
    input  pipe_en_t                         en,
    input  logic [DIMS-1:0][EXT_WIDTH-1:0]   term_a,
    input  logic [DIMS-1:0][EXT_WIDTH-1:0]   term_b,
    output logic                             too_far
);

    logic [EXT_WIDTH-1:0] sum_a_reg, sum_a_next, sum_b_reg, sum_b_next;
    logic [EXT_WIDTH-1:0] dbl;
    logic                 flag_reg, flag_next;

    always_comb
    begin
        sum_a_next = '0;
        sum_b_next = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            sum_a_next = sum_a_next + term_a[d];
            sum_b_next = sum_b_next + term_b[d];
        end
    end

    // doubling wraps: the top bit falls off
    assign dbl       = {sum_b_reg[EXT_WIDTH-2:0], 1'b0};
    assign flag_next = $signed(sum_a_reg) > $signed(dbl);

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (en.flag)
        begin
            flag_reg <= flag_next;
        end
    end

    assign too_far = flag_reg;

endmodule

FILE: rtl/kmeans_box_prune_test_core.sv
// Top level of the k-means box pruning test: lanes, merge and pipeline control.
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------------
//  in      | in_valid / in_ready     | closest_centre, candidate_centre, box_low, box_high
//  out     | out_valid / out_ready   | too_far
//
// One word in and one word out per cycle when the output is taken every cycle.
// Stages in order: operand register, multiplier register in each lane,
// sum register and compare register in the merge stage.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles close up and in_ready drops only when all four stages are full and
// the output word is held. Reset clears the stage valid flags only.
`timescale 1ns / 1ps

module kmeans_box_prune_test_core
    import kbpt_pkg::*;
#(
    parameter int DIMS          = 3,
    parameter int COORD_WIDTH   = 16,
    parameter int EXT_WIDTH     = 32,
    parameter int MUL_INT_BITS  = 13,
    parameter int MUL_FRAC_BITS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [IN_WIDTH-1:0] closest_centre,
    input  logic [IN_WIDTH-1:0] candidate_centre,
    input  logic [IN_WIDTH-1:0] box_low,
    input  logic [IN_WIDTH-1:0] box_high,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                too_far
);

    // coordinates past the input field read as zero
    localparam int PW = (DIMS * COORD_WIDTH > IN_WIDTH) ? DIMS * COORD_WIDTH : IN_WIDTH;

    logic [PW-1:0] cl_pad, ca_pad, lo_pad, hi_pad;
    logic [DIMS-1:0][EXT_WIDTH-1:0] term_a, term_b;
    logic     v_op_reg, v_prod_reg, v_sum_reg, v_flag_reg;
    pipe_en_t en;

    assign cl_pad = PW'(closest_centre);
    assign ca_pad = PW'(candidate_centre);
    assign lo_pad = PW'(box_low);
    assign hi_pad = PW'(box_high);

    assign en.flag = !v_flag_reg || out_ready;
    assign en.sum  = !v_sum_reg  || en.flag;
    assign en.prod = !v_prod_reg || en.sum;
    assign en.op   = !v_op_reg   || en.prod;

    assign in_ready  = en.op;
    assign out_valid = v_flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_op_reg   <= 1'b0;
            v_prod_reg <= 1'b0;
            v_sum_reg  <= 1'b0;
            v_flag_reg <= 1'b0;
        end
        else
        begin
            if (en.op)
                v_op_reg <= in_valid;
            if (en.prod)
                v_prod_reg <= v_op_reg;
            if (en.sum)
                v_sum_reg <= v_prod_reg;
            if (en.flag)
                v_flag_reg <= v_sum_reg;
        end
    end

    for (genvar d = 0; d < DIMS; d++)
    begin : g_lane
        kbpt_lane #(
            .COORD_WIDTH   (COORD_WIDTH),
            .EXT_WIDTH     (EXT_WIDTH),
            .MUL_INT_BITS  (MUL_INT_BITS),
            .MUL_FRAC_BITS (MUL_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .closest (cl_pad[d*COORD_WIDTH +: COORD_WIDTH]),
            .cand    (ca_pad[d*COORD_WIDTH +: COORD_WIDTH]),
            .lo      (lo_pad[d*COORD_WIDTH +: COORD_WIDTH]),
            .hi      (hi_pad[d*COORD_WIDTH +: COORD_WIDTH]),
            .term_a  (term_a[d]),
            .term_b  (term_b[d])
        );
    end

    kbpt_merge #(
        .DIMS      (DIMS),
        .EXT_WIDTH (EXT_WIDTH)
    ) u_merge (
        .clk     (clk),
        .en      (en),
        .term_a  (term_a),
        .term_b  (term_b),
        .too_far (too_far)
    );

    // a full pipeline with a held output word must refuse input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v_op_reg && v_prod_reg && v_sum_reg && v_flag_reg && !out_ready) |-> !in_ready)
        else $error("input taken while pipeline is full and stalled");

    // an accepted word lands in the operand stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v_op_reg)
        else $error("accepted word lost at operand stage");

    // an output word only appears after the sum stage held one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v_sum_reg))
        else $error("output word without a word in the sum stage");

    // a waiting sum word is never overwritten while the output is held
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v_sum_reg && v_flag_reg && !out_ready) |=> v_sum_reg)
        else $error("sum stage word dropped during stall");

endmodule

FILE: tb/sv/kmeans_box_prune_test_core_checker.sv
// Watches both channels of the box pruning core, predicts each verdict and compares it.
`timescale 1ns / 1ps

module kmeans_box_prune_test_core_checker
    import kbpt_pkg::*;
#(
    parameter int DIMS          = 3,
    parameter int COORD_WIDTH   = 16,
    parameter int EXT_WIDTH     = 32,
    parameter int MUL_INT_BITS  = 13,
    parameter int MUL_FRAC_BITS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [IN_WIDTH-1:0] closest_centre,
    input  logic [IN_WIDTH-1:0] candidate_centre,
    input  logic [IN_WIDTH-1:0] box_low,
    input  logic [IN_WIDTH-1:0] box_high,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                too_far,
    output int                  fail_count,
    output int                  verdicts_owed
);

    localparam int MUL_BITS = MUL_INT_BITS + MUL_FRAC_BITS;

    typedef struct {
        int unsigned seq;
        logic        verdict;
    } owed_verdict_t;

    owed_verdict_t owed_q[$];
    int unsigned   words_in;

    // wrap to EXT_WIDTH bits and sign-extend back to 64
    function automatic logic signed [63:0] wrap_ext(input logic [63:0] v);
        logic signed [EXT_WIDTH-1:0] t;
        logic signed [63:0]          r;
        t = v[EXT_WIDTH-1:0];
        r = t;
        return r;
    endfunction

    // coordinate d of a packed word; bits past the port read as zero
    function automatic logic signed [63:0] coord_at(input logic [IN_WIDTH-1:0] w, input int d);
        logic [63:0]                   wz;
        logic [63:0]                   sh;
        logic signed [COORD_WIDTH-1:0] t;
        logic signed [63:0]            r;
        wz = w;
        if (d * COORD_WIDTH >= 64)
            return 64'sd0;
        sh = wz >> (d * COORD_WIDTH);
        t  = sh[COORD_WIDTH-1:0];
        r  = t;
        return r;
    endfunction

    function automatic logic signed [63:0] clamp_operand(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (MUL_BITS - 1)) - 64'sd1;
        lo_lim = -hi_lim - 64'sd1;
        if (v > hi_lim)
            return hi_lim;
        if (v < lo_lim)
            return lo_lim;
        return v;
    endfunction

    function automatic logic signed [63:0] fixed_mul(input logic signed [63:0] x,
                                                    input logic signed [63:0] y);
        logic signed [127:0] px;
        logic signed [127:0] py;
        logic signed [127:0] p;
        px = clamp_operand(x);
        py = clamp_operand(y);
        p  = px * py;
        p  = p >>> MUL_FRAC_BITS;
        return wrap_ext(p[63:0]);
    endfunction

    function automatic logic prune_verdict(input logic [IN_WIDTH-1:0] cl_w,
                                           input logic [IN_WIDTH-1:0] ca_w,
                                           input logic [IN_WIDTH-1:0] lo_w,
                                           input logic [IN_WIDTH-1:0] hi_w);
        logic [EXT_WIDTH-1:0] sum_a;
        logic [EXT_WIDTH-1:0] sum_b;
        logic [EXT_WIDTH-1:0] twice_b;
        logic signed [63:0]   cl;
        logic signed [63:0]   ca;
        logic signed [63:0]   c;
        logic signed [63:0]   corner;
        logic signed [63:0]   diff;
        logic signed [63:0]   term_a;
        logic signed [63:0]   term_b;
        sum_a = '0;
        sum_b = '0;
        for (int d = 0; d < DIMS; d++)
        begin
            cl     = coord_at(cl_w, d);
            ca     = coord_at(ca_w, d);
            c      = wrap_ext(ca - cl);
            corner = (c > 0) ? coord_at(hi_w, d) : coord_at(lo_w, d);
            diff   = wrap_ext(corner - cl);
            term_a = fixed_mul(c, c);
            term_b = fixed_mul(diff, c);
            sum_a  = sum_a + term_a[EXT_WIDTH-1:0];
            sum_b  = sum_b + term_b[EXT_WIDTH-1:0];
        end
        twice_b = sum_b << 1;
        return ($signed(sum_a) > $signed(twice_b)) ? 1'b1 : 1'b0;
    endfunction

    always @(posedge clk)
    begin
        owed_verdict_t head;
        if (!rst_n)
        begin
            fail_count = 0;
            words_in   = 0;
            owed_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                owed_q.push_back('{words_in,
                    prune_verdict(closest_centre, candidate_centre, box_low, box_high)});
                words_in++;
            end
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: output word too_far=%b with no verdict owed",
                                 too_far);
                end
                else
                begin
                    head = owed_q.pop_front();
                    if (too_far !== head.verdict)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: word %0d too_far expected %b got %b",
                                     head.seq, head.verdict, too_far);
                    end
                end
            end
        end
        verdicts_owed <= owed_q.size();
    end

endmodule

FILE: tb/sv/kmeans_box_prune_test_core_tb.sv
// Stimulus, reset and verdict for the box pruning core testbench.
`timescale 1ns / 1ps

module kmeans_box_prune_test_core_tb;

    import kbpt_pkg::*;

    localparam int DIMS          = 3;
    localparam int COORD_WIDTH   = 16;
    localparam int EXT_WIDTH     = 32;
    localparam int MUL_INT_BITS  = 13;
    localparam int MUL_FRAC_BITS = 4;

    localparam int RANDOM_WORDS = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE       = 12;
    localparam int LONG_HOLD    = 200;

    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_ready;
    logic [IN_WIDTH-1:0] closest_centre   = '0;
    logic [IN_WIDTH-1:0] candidate_centre = '0;
    logic [IN_WIDTH-1:0] box_low          = '0;
    logic [IN_WIDTH-1:0] box_high         = '0;
    logic                out_valid;
    logic                out_ready        = 1'b0;
    logic                too_far;

    int fail_count;
    int verdicts_owed;
    int cycle_count = 0;
    int burst_left  = 0;

    kmeans_box_prune_test_core #(
        .DIMS          (DIMS),
        .COORD_WIDTH   (COORD_WIDTH),
        .EXT_WIDTH     (EXT_WIDTH),
        .MUL_INT_BITS  (MUL_INT_BITS),
        .MUL_FRAC_BITS (MUL_FRAC_BITS)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .closest_centre   (closest_centre),
        .candidate_centre (candidate_centre),
        .box_low          (box_low),
        .box_high         (box_high),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .too_far          (too_far)
    );

    kmeans_box_prune_test_core_checker #(
        .DIMS          (DIMS),
        .COORD_WIDTH   (COORD_WIDTH),
        .EXT_WIDTH     (EXT_WIDTH),
        .MUL_INT_BITS  (MUL_INT_BITS),
        .MUL_FRAC_BITS (MUL_FRAC_BITS)
    ) verdict_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .closest_centre   (closest_centre),
        .candidate_centre (candidate_centre),
        .box_low          (box_low),
        .box_high         (box_high),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .too_far          (too_far),
        .fail_count       (fail_count),
        .verdicts_owed    (verdicts_owed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** kmeans_box_prune_test_core: FAILED **");
            $finish;
        end
    end

    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic logic [IN_WIDTH-1:0] pack3(input int c0, input int c1, input int c2);
        logic [IN_WIDTH-1:0] w;
        w = '0;
        w[15:0]  = c0[15:0];
        w[31:16] = c1[15:0];
        w[47:32] = c2[15:0];
        return w;
    endfunction

    // favour the ends of the range and small values around zero
    function automatic int pick_coord();
        case ($urandom_range(0, 5))
            0:       return -32768 + int'($urandom_range(0, 3));
            1:       return 32767 - int'($urandom_range(0, 3));
            2:       return int'($urandom_range(0, 64)) - 32;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    task automatic make_word(output logic [IN_WIDTH-1:0] cl_w, output logic [IN_WIDTH-1:0] ca_w,
                             output logic [IN_WIDTH-1:0] lo_w, output logic [IN_WIDTH-1:0] hi_w);
        int kind;
        int lo;
        int hi;
        int span;
        int cl;
        int ca;
        int tmp;
        kind = $urandom_range(0, 9);
        cl_w = '0;
        ca_w = '0;
        lo_w = '0;
        hi_w = '0;
        if (kind < 2)
        begin
            cl_w = IN_WIDTH'({$urandom(), $urandom()});
            ca_w = IN_WIDTH'({$urandom(), $urandom()});
            lo_w = IN_WIDTH'({$urandom(), $urandom()});
            hi_w = IN_WIDTH'({$urandom(), $urandom()});
        end
        else
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                lo   = pick_coord();
                span = $urandom_range(0, 1) ? int'($urandom_range(0, 64))
                                            : int'($urandom_range(0, 65535));
                hi   = sat16(lo + span);
                if ($urandom_range(0, 9) < 7)
                    cl = lo + int'($urandom_range(0, hi - lo));
                else
                    cl = pick_coord();
                case ($urandom_range(0, 3))
                    0:       ca = cl;
                    1:       ca = sat16(cl + int'($urandom_range(0, 80)) - 40);
                    2:       ca = pick_coord();
                    default: ca = lo + int'($urandom_range(0, hi - lo));
                endcase
                // inverted box
                if (kind == 2)
                begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                cl_w[d*COORD_WIDTH +: COORD_WIDTH] = cl[COORD_WIDTH-1:0];
                ca_w[d*COORD_WIDTH +: COORD_WIDTH] = ca[COORD_WIDTH-1:0];
                lo_w[d*COORD_WIDTH +: COORD_WIDTH] = lo[COORD_WIDTH-1:0];
                hi_w[d*COORD_WIDTH +: COORD_WIDTH] = hi[COORD_WIDTH-1:0];
            end
        end
    endtask

    // offer one word after any gap the burst pattern calls for; hold until taken
    task automatic send(input logic [IN_WIDTH-1:0] cl_w, input logic [IN_WIDTH-1:0] ca_w,
                        input logic [IN_WIDTH-1:0] lo_w, input logic [IN_WIDTH-1:0] hi_w);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : int'($urandom_range(1, 40));
        end
        burst_left--;
        in_valid         <= 1'b1;
        closest_centre   <= cl_w;
        candidate_centre <= ca_w;
        box_low          <= lo_w;
        box_high         <= hi_w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (verdicts_owed != 0)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold-off, then changing patterns
    initial
    begin
        int mode;
        int len;
        wait (rst_n === 1'b1);
        @(posedge clk);
        repeat (600)
        begin
            out_ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 4);
            len  = $urandom_range(1, 60);
            repeat (len)
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        logic [IN_WIDTH-1:0] g_cl;
        logic [IN_WIDTH-1:0] g_ca;
        logic [IN_WIDTH-1:0] g_lo;
        logic [IN_WIDTH-1:0] g_hi;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send('0, '0, '0, '0);
        // candidate inside the box, then far outside it
        send(pack3(0, 0, 0), pack3(1, 1, 1), pack3(-8, -8, -8), pack3(8, 8, 8));
        send(pack3(0, 0, 0), pack3(100, 100, 100), pack3(-10, -10, -10), pack3(10, 10, 10));
        // candidate equal to closest: zero difference picks the low corner
        send(pack3(5, -5, 7), pack3(5, -5, 7), pack3(-300, 2, 9), pack3(40, 41, 42));
        // extreme coordinates, largest differences in both directions
        send(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
             pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767));
        send(pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768),
             pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767));
        send(pack3(-32768, 32767, -32768), pack3(32767, -32768, 32767),
             pack3(0, 0, 0), pack3(0, 0, 0));
        send({IN_WIDTH{1'b1}}, {IN_WIDTH{1'b1}}, {IN_WIDTH{1'b1}}, {IN_WIDTH{1'b1}});
        send('0, '0, '0, {IN_WIDTH{1'b1}});
        send('0, {IN_WIDTH{1'b1}}, {IN_WIDTH{1'b1}}, '0);
        // mixed signs across dimensions
        send(pack3(0, 0, 0), pack3(50, -50, 0), pack3(-20, -20, -20), pack3(20, 20, 20));
        // single active dimension, sum_a equal to twice sum_b, then just over
        send(pack3(0, 0, 0), pack3(32, 0, 0), pack3(0, 0, 0), pack3(16, 0, 0));
        send(pack3(0, 0, 0), pack3(32, 0, 0), pack3(0, 0, 0), pack3(15, 0, 0));
        // products lost to the fractional shift
        send(pack3(0, 0, 0), pack3(1, 1, 1), pack3(0, 0, 0), pack3(0, 0, 0));
        send(pack3(0, 0, 0), pack3(-3, -3, -3), pack3(-1, -1, -1), pack3(0, 0, 0));
        // inverted boxes
        send(pack3(0, 0, 0), pack3(30, -30, 30), pack3(10, 10, 10), pack3(-10, -10, -10));
        send(pack3(0, 0, 0), pack3(-200, 200, 1), pack3(32767, 32767, 32767),
             pack3(-32768, -32768, -32768));
        send(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
        send(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
        send(pack3(-1, 1, -1), pack3(1, -1, 1), pack3(-32768, -32768, -32768),
             pack3(32767, 32767, 32767));
        drain();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 2)
                drain();
            make_word(g_cl, g_ca, g_lo, g_hi);
            send(g_cl, g_ca, g_lo, g_hi);
        end
        drain();
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && verdicts_owed == 0)
            $display("** kmeans_box_prune_test_core: PASSED **");
        else
            $display("** kmeans_box_prune_test_core: FAILED **");
        $finish;
    end

endmodule

FILE: kmeans_box_prune_test_core.f
rtl/kbpt_pkg.sv
rtl/kbpt_lane.sv
rtl/kbpt_merge.sv
rtl/kmeans_box_prune_test_core.sv
tb/sv/kmeans_box_prune_test_core_checker.sv
tb/sv/kmeans_box_prune_test_core_tb.sv
